// ----- hw/rtl/adzba_pkg.sv -----
package adzba_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int KSIZE_W   = 7;
    localparam int MODE_W    = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DZONE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KSIZE  = 3'd4;

    // filter modes
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PASS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AVG  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LAST = 2'd3;

    // reset values
    localparam logic [MODE_W-1:0]          RST_MODE  = MODE_AVG;
    localparam logic signed [SAMPLE_W-1:0] RST_LOWER = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] RST_UPPER = 16'sh7fff;
    localparam logic [SAMPLE_W-1:0]        RST_DZONE = 16'h0000;
    localparam logic [KSIZE_W-1:0]         RST_KSIZE = 7'd1;

    typedef struct packed {
        logic load;
        logic eval;
        logic put;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic need_div;
        logic div_done;
        logic out_busy;
    } t_status;

endpackage

// ----- hw/rtl/adzba_if.sv -----
interface adzba_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [adzba_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface adzba_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [adzba_pkg::SAMPLE_W-1:0]  filtered_value;

    modport source (output valid, output filtered_value, input ready);
    modport sink   (input valid, input filtered_value, output ready);
endinterface

interface adzba_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [adzba_pkg::CFG_IDX_W-1:0]     index;
    logic [adzba_pkg::CFG_DAT_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/adzba_div.sv -----
module adzba_div #(
    parameter int SUM_W = 22,
    parameter int KW    = 7
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [SUM_W-1:0]               i_dividend,
    input  logic [KW-1:0]                         i_divisor,
    output logic                                  o_done,
    output logic signed [adzba_pkg::SAMPLE_W-1:0] o_quotient
);

    localparam int CNTW = $clog2(SUM_W + 1);

    logic [CNTW-1:0]  r_cnt, n_cnt;
    logic             r_neg;
    logic [SUM_W-1:0] r_quo;
    logic [KW-1:0]    r_rem;
    logic [KW-1:0]    r_div;
    logic [KW:0]      trial;
    logic             fits;
    logic [SUM_W-1:0] quo_s;

    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_comb begin
        n_cnt = r_cnt;
        if (i_start) begin
            n_cnt = CNTW'(SUM_W);
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // restoring division on the magnitude, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_quo <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? KW'(trial - {1'b0, r_div}) : KW'(trial);
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
    end

    assign quo_s      = r_neg ? SUM_W'(-r_quo) : r_quo;
    assign o_quotient = quo_s[adzba_pkg::SAMPLE_W-1:0];
    assign o_done     = (r_cnt == '0);

endmodule

// ----- hw/rtl/adzba_dp.sv -----
module adzba_dp #(
    parameter int MAX_KERNEL = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [adzba_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [adzba_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    input  logic signed [adzba_pkg::SAMPLE_W-1:0] i_sample,
    input  adzba_pkg::t_cmd                       i_cmd,
    output adzba_pkg::t_status                    o_status,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic signed [adzba_pkg::SAMPLE_W-1:0] o_out_data
);

    localparam int SW    = adzba_pkg::SAMPLE_W;
    localparam int KW    = $clog2(MAX_KERNEL + 1);
    localparam int SUM_W = SW + $clog2(MAX_KERNEL);

    logic [adzba_pkg::MODE_W-1:0]  r_mode;
    logic signed [SW-1:0]          r_lower;
    logic signed [SW-1:0]          r_upper;
    logic [SW-1:0]                 r_dzone;
    logic [adzba_pkg::KSIZE_W-1:0] r_ksize;

    logic                 r_in_dz, r_in_low, r_in_high;
    logic [KW-1:0]        r_count;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SW-1:0] r_sample;
    logic signed [SW-1:0] r_result;
    logic                 r_use_div;
    logic                 r_out_valid;
    logic signed [SW-1:0] r_out_data;

    logic                 cfg_clear;
    logic [KW-1:0]        k;
    logic signed [SW:0]   s_ext;
    logic [SW:0]          mag;
    logic                 in_dz, dz_drop;
    logic signed [SW-1:0] s1, s2;
    logic                 is_low, is_high, keep;
    logic [KW-1:0]        count_new;
    logic signed [SUM_W-1:0] sum_new;
    logic                 full;
    logic                 block_mode;
    logic                 emit, need_div;
    logic                 div_done;
    logic signed [SW-1:0] div_quo;

    // configuration registers
    always_comb begin
        cfg_clear = 1'b0;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                adzba_pkg::REG_MODE, adzba_pkg::REG_LOWER, adzba_pkg::REG_UPPER,
                adzba_pkg::REG_DZONE, adzba_pkg::REG_KSIZE: cfg_clear = 1'b1;
                default: cfg_clear = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= adzba_pkg::RST_MODE;
            r_lower <= adzba_pkg::RST_LOWER;
            r_upper <= adzba_pkg::RST_UPPER;
            r_dzone <= adzba_pkg::RST_DZONE;
            r_ksize <= adzba_pkg::RST_KSIZE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                adzba_pkg::REG_MODE:  r_mode  <= i_cfg_data[adzba_pkg::MODE_W-1:0];
                adzba_pkg::REG_LOWER: r_lower <= i_cfg_data;
                adzba_pkg::REG_UPPER: r_upper <= i_cfg_data;
                adzba_pkg::REG_DZONE: r_dzone <= i_cfg_data;
                adzba_pkg::REG_KSIZE: r_ksize <= i_cfg_data[adzba_pkg::KSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // effective kernel size
    always_comb begin
        if (32'(r_ksize) > MAX_KERNEL) begin
            k = KW'(MAX_KERNEL);
        end else if (r_ksize == '0) begin
            k = KW'(1);
        end else begin
            k = KW'(r_ksize);
        end
    end

    // zone tests
    assign s_ext   = (SW+1)'(r_sample);
    assign mag     = r_sample[SW-1] ? (SW+1)'(-s_ext) : (SW+1)'(s_ext);
    assign in_dz   = mag < {1'b0, r_dzone};
    assign dz_drop = in_dz && r_in_dz;
    assign s1      = in_dz ? '0 : r_sample;
    assign is_low  = s1 < r_lower;
    assign is_high = !is_low && (s1 > r_upper);
    assign s2      = is_low ? r_lower : (is_high ? r_upper : s1);
    assign keep    = !dz_drop && !(is_low && r_in_low) && !(is_high && r_in_high);

    assign count_new  = r_count + 1'b1;
    assign sum_new    = r_sum + SUM_W'(s2);
    assign full       = count_new >= k;
    assign block_mode = (r_mode == adzba_pkg::MODE_AVG) || (r_mode == adzba_pkg::MODE_LAST);

    always_comb begin
        emit     = 1'b0;
        need_div = 1'b0;
        unique case (r_mode)
            adzba_pkg::MODE_NONE: emit = 1'b0;
            adzba_pkg::MODE_PASS: emit = 1'b1;
            adzba_pkg::MODE_AVG: begin
                emit     = keep && full;
                need_div = keep && full;
            end
            adzba_pkg::MODE_LAST: emit = keep && full;
            default: emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_dz   <= 1'b0;
            r_in_low  <= 1'b0;
            r_in_high <= 1'b0;
            r_count   <= '0;
            r_sum     <= '0;
        end else if (cfg_clear) begin
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.eval && block_mode && !dz_drop) begin
            r_in_dz   <= in_dz;
            r_in_low  <= is_low;
            r_in_high <= is_high;
            if (keep) begin
                if (full) begin
                    r_count <= '0;
                    r_sum   <= '0;
                end else begin
                    r_count <= count_new;
                    r_sum   <= sum_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.eval) begin
            r_result  <= (r_mode == adzba_pkg::MODE_PASS) ? r_sample : s2;
            r_use_div <= need_div;
        end
    end

    adzba_div #(
        .SUM_W (SUM_W),
        .KW    (KW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.eval && need_div),
        .i_dividend (sum_new),
        .i_divisor  (k),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.put) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_out_data <= r_use_div ? div_quo : r_result;
        end
    end

    assign o_status.emit     = emit;
    assign o_status.need_div = need_div;
    assign o_status.div_done = div_done;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- hw/rtl/adzba_ctrl.sv -----
module adzba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  adzba_pkg::t_status i_status,
    output adzba_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_PUT  = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (!i_status.emit) begin
                    n_state = S_IDLE;
                end else if (i_status.need_div) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.put = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/analog_axis_deadzone_block_average.sv -----
// Analog axis filter: deadzone, edge clamp and block averaging of signed samples.
// Channels: i_in carries one sample per request, o_out one filtered value,
// i_cfg writes a register (0 mode, 1 lower bound, 2 upper bound, 3 deadzone,
// 4 kernel size); i_cfg is always ready and any valid index clears the block.
// A request is taken when valid and ready are both high.
// Steps: a request is loaded in the idle state and evaluated in the eval state;
// a sample that gives no output then frees the input, while a pass-mode sample or
// a last-of-block value goes through the put step into the output register. A
// block end in average mode first waits in a divide state for the bit-serial
// divider, which produces one quotient bit a cycle. One sample is in work at a
// time: the input is not ready until the previous sample ends or is put.
// The output register holds the result while o_out is stalled; the next sample
// is taken meanwhile and waits in its put step until the register frees up.
// Reset (synchronous, active low) returns registers to their defaults (mode
// block average, full range bounds, no deadzone, kernel 1) and empties the block.
module analog_axis_deadzone_block_average #(
    parameter int MAX_KERNEL = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    adzba_in_if.sink    i_in,
    adzba_out_if.source o_out,
    adzba_cfg_if.sink   i_cfg
);

    adzba_pkg::t_cmd    cmd;
    adzba_pkg::t_status status;

    assign i_cfg.ready = 1'b1;

    adzba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    adzba_dp #(
        .MAX_KERNEL (MAX_KERNEL)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_sample    (i_in.sample),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.filtered_value)
    );

endmodule

// ----- hw/rtl/adzba_chk.sv -----
module adzba_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  i_in_ready,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic signed [adzba_pkg::SAMPLE_W-1:0] i_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // one sample in work at a time
    a_in_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken twice in a row");

    // no result right after a request
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result too early");

    // reset empties the output
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind analog_axis_deadzone_block_average adzba_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.filtered_value)
);
